/* hw/rtl/fcvm_pkg.sv */
`timescale 1ns / 1ps

package fcvm_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [15:0] t_q14;

    localparam int ANGLE_LIMIT  = 90;
    localparam int CORDIC_STEPS = 16;
    localparam int DEG_Q30      = 18740330;
    localparam int CORDIC_K     = 652032874;

    localparam logic signed [7:0] PITCH_MAX = 8'(ANGLE_LIMIT);
    localparam logic signed [7:0] PITCH_MIN = -PITCH_MAX;
    localparam logic [8:0] YAW_FULL = 9'd360;
    localparam logic [8:0] YAW_TOP  = 9'd359;

    localparam logic [3:0] OP_FWD       = 4'd0;
    localparam logic [3:0] OP_BACK      = 4'd1;
    localparam logic [3:0] OP_RIGHT     = 4'd2;
    localparam logic [3:0] OP_LEFT      = 4'd3;
    localparam logic [3:0] OP_PITCH_UP  = 4'd4;
    localparam logic [3:0] OP_PITCH_DN  = 4'd5;
    localparam logic [3:0] OP_YAW_UP    = 4'd6;
    localparam logic [3:0] OP_YAW_DN    = 4'd7;
    localparam logic [3:0] OP_VIEW      = 4'd8;
    localparam logic [3:0] OP_SET_POS   = 4'd9;
    localparam logic [3:0] OP_SET_FRONT = 4'd10;

    localparam logic [2:0] CFG_UP_X  = 3'd0;
    localparam logic [2:0] CFG_UP_Y  = 3'd1;
    localparam logic [2:0] CFG_UP_Z  = 3'd2;
    localparam logic [2:0] CFG_SPEED = 3'd3;
    localparam logic [2:0] CFG_ACCEL = 3'd4;

    // Multiplier word lengths: operands of up to 18 signed bits, or full words.
    localparam logic [5:0] MUL_SHORT = 6'd18;
    localparam logic [5:0] MUL_LONG  = 6'd32;

    // atan(2^-i) in radians, Q.30, truncated.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sd843314856;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043836;
            5'd3:  atan_q30 = 34'sd133525158;
            5'd4:  atan_q30 = 34'sd67021686;
            5'd5:  atan_q30 = 34'sd33543515;
            5'd6:  atan_q30 = 34'sd16775850;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194282;
            5'd9:  atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048575;
            5'd11: atan_q30 = 34'sd524287;
            5'd12: atan_q30 = 34'sd262143;
            5'd13: atan_q30 = 34'sd131071;
            5'd14: atan_q30 = 34'sd65535;
            5'd15: atan_q30 = 34'sd32767;
            5'd16: atan_q30 = 34'sd16383;
            5'd17: atan_q30 = 34'sd8191;
            5'd18: atan_q30 = 34'sd4095;
            5'd19: atan_q30 = 34'sd2047;
            5'd20: atan_q30 = 34'sd1023;
            5'd21: atan_q30 = 34'sd511;
            5'd22: atan_q30 = 34'sd255;
            5'd23: atan_q30 = 34'sd127;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

    function automatic t_q16 sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic t_q14 sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    function automatic t_q14 clamp_unit(input logic signed [33:0] v);
        if (v > 34'sd16384) begin
            clamp_unit = 16'sd16384;
        end else if (v < -34'sd16384) begin
            clamp_unit = -16'sd16384;
        end else begin
            clamp_unit = v[15:0];
        end
    endfunction

endpackage

/* hw/rtl/fly_camera_view_matrix.sv */
// First-person camera engine. Each request carries one command (move forward, back, right or
// left, pitch or yaw by one degree, view, set position, set front), optionally loading pitch and
// yaw first. Only a view produces results: four matrix columns of the right-handed lookAt view
// matrix, the fourth marked by tlast. All arithmetic runs on one bit-serial multiplier (one bit of
// the multiplier word per cycle, 18 or 32 bits), an iterative CORDIC (one rotation per cycle),
// a bit-per-cycle square root and a bit-per-cycle divider, one component at a time. Pitch, yaw,
// set and unused commands complete on acceptance without leaving the idle state. A new request is
// taken only when the sequencer is idle, while the last column of a view may still wait in the
// output register.
`timescale 1ns / 1ps

module fly_camera_view_matrix
    import fcvm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // value_x[31:0], value_y[63:32], value_z[95:64], pitch_in[103:96], yaw_in[112:104], zeros
    input  logic [119:0] s_axis_tdata,
    // operation[3:0], load_angles[4]
    input  logic [4:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // column_index[1:0], row0[33:2], row1[65:34], row2[97:66], row3[129:98], zeros
    output logic [135:0] m_axis_tdata,
    // last_column
    output logic         m_axis_tlast,

    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRIG  = 4'd1;
    localparam logic [3:0] S_FMUL  = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_STEP  = 4'd7;
    localparam logic [3:0] S_MOVE  = 4'd8;
    localparam logic [3:0] S_DOT   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    // Sequencer.
    logic [3:0]  r_state;
    logic        r_ph;
    logic [1:0]  r_i;
    logic [1:0]  r_t;
    logic        r_upass;
    logic [3:0]  r_op;

    // Configuration.
    t_q14        r_up [3];
    logic [15:0] r_speed;
    logic [9:0]  r_accel;

    // Camera state.
    t_q16        r_pos [3];
    t_q14        r_front [3];
    logic signed [7:0] r_pitch;
    logic [8:0]  r_yaw;

    // CORDIC.
    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]  r_j;
    logic        r_tneg;
    t_q14        r_sp, r_cp, r_sy, r_cy;

    // Serial multiplier and accumulator.
    logic signed [63:0] r_ma;
    logic [31:0] r_mb;
    logic [5:0]  r_mcnt;
    logic signed [63:0] r_acc;

    // Cross product, norm and division.
    t_q16        r_c [3];
    logic [63:0] r_sv, r_sr, r_bit;
    logic [31:0] r_m;
    logic [32:0] r_dr;
    logic [14:0] r_q;
    logic [3:0]  r_dcnt;
    logic        r_dneg;

    t_q14        r_s [3];
    logic signed [17:0] r_u [3];
    logic [25:0] r_step;
    t_q16        r_col3 [3];

    logic        r_ovalid;
    logic [135:0] r_odata;
    logic        r_olast;

    // Input fields.
    logic [3:0]  w_op;
    logic        w_load;
    t_q16        w_val [3];
    logic signed [7:0] w_pitch_in;
    logic [8:0]  w_yaw_in;
    logic        w_accept;

    assign w_op       = s_axis_tuser[3:0];
    assign w_load     = s_axis_tuser[4];
    assign w_val[0]   = s_axis_tdata[31:0];
    assign w_val[1]   = s_axis_tdata[63:32];
    assign w_val[2]   = s_axis_tdata[95:64];
    assign w_pitch_in = s_axis_tdata[103:96];
    assign w_yaw_in   = s_axis_tdata[112:104];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // Angles after an optional load and after the one-degree commands.
    logic signed [7:0] w_pbase, n_pitch;
    logic [8:0]  w_ybase, n_yaw;

    always_comb begin
        w_pbase = r_pitch;
        w_ybase = r_yaw;
        if (w_load) begin
            if (w_pitch_in > PITCH_MAX) begin
                w_pbase = PITCH_MAX;
            end else if (w_pitch_in < PITCH_MIN) begin
                w_pbase = PITCH_MIN;
            end else begin
                w_pbase = w_pitch_in;
            end
            w_ybase = (w_yaw_in >= YAW_FULL) ? w_yaw_in - YAW_FULL : w_yaw_in;
        end
        n_pitch = w_pbase;
        n_yaw   = w_ybase;
        unique case (w_op)
            OP_PITCH_UP: n_pitch = (w_pbase >= PITCH_MAX) ? PITCH_MAX : w_pbase + 8'sd1;
            OP_PITCH_DN: n_pitch = (w_pbase <= PITCH_MIN) ? PITCH_MIN : w_pbase - 8'sd1;
            OP_YAW_UP:   n_yaw   = (w_ybase >= YAW_TOP) ? 9'd0 : w_ybase + 9'd1;
            OP_YAW_DN:   n_yaw   = (w_ybase == 9'd0) ? YAW_TOP : w_ybase - 9'd1;
            default: ;
        endcase
    end

    // Set front rounds each value by two bits and saturates it.
    t_q14 n_front [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_front[k] = sat16((34'(w_val[k]) + 34'sd2) >>> 2);
        end
    end

    // CORDIC start angle: yaw is folded into the right half plane, with both results negated
    // when it was taken from the left half.
    logic signed [9:0]  w_deg, w_dred;
    logic               w_dneg;
    logic signed [33:0] w_zinit, w_dx, w_dy, w_at, w_xr, w_yr;
    t_q14               w_cx, w_cy;

    always_comb begin
        w_deg  = (r_i == 2'd0) ? 10'(r_pitch) : $signed({1'b0, r_yaw});
        w_dred = w_deg;
        w_dneg = 1'b0;
        if (w_deg > 10'sd270) begin
            w_dred = w_deg - 10'sd360;
        end else if (w_deg > 10'sd90) begin
            w_dred = w_deg - 10'sd180;
            w_dneg = 1'b1;
        end
        w_zinit = 34'(w_dred) * 34'(DEG_Q30);
        w_dx    = r_y >>> r_j;
        w_dy    = r_x >>> r_j;
        w_at    = atan_q30(r_j);
        w_xr    = (r_x + 34'sd32768) >>> 16;
        w_yr    = (r_y + 34'sd32768) >>> 16;
        w_cx    = r_tneg ? -clamp_unit(w_xr) : clamp_unit(w_xr);
        w_cy    = r_tneg ? -clamp_unit(w_yr) : clamp_unit(w_yr);
    end

    // Multiplier operands for the job that the sequencer is about to start.
    t_q16       m_a, m_b;
    logic [5:0] m_len;
    logic       m_neg, m_clr;
    logic [1:0] w_i1, w_i2, w_ai, w_bi;

    always_comb begin
        w_i1  = (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
        w_i2  = (r_i == 2'd0) ? 2'd2 : r_i - 2'd1;
        w_ai  = (r_t == 2'd0) ? w_i1 : w_i2;
        w_bi  = (r_t == 2'd0) ? w_i2 : w_i1;
        m_a   = '0;
        m_b   = '0;
        m_len = MUL_SHORT;
        m_neg = 1'b0;
        m_clr = 1'b1;
        unique case (r_state)
            S_FMUL: begin
                m_a = (r_i == 2'd0) ? 32'(r_cy) : 32'(r_sy);
                m_b = 32'(r_cp);
            end
            S_CROSS: begin
                m_a   = r_upass ? 32'(r_s[w_ai]) : 32'(r_front[w_ai]);
                m_b   = r_upass ? 32'(r_front[w_bi]) : 32'(r_up[w_bi]);
                m_neg = (r_t != 2'd0);
                m_clr = (r_t == 2'd0);
            end
            S_SQ: begin
                m_a   = r_c[r_i];
                m_b   = r_c[r_i];
                m_len = MUL_LONG;
                m_clr = (r_i == 2'd0);
            end
            S_STEP: begin
                m_a = {16'd0, r_speed};
                m_b = {22'd0, r_accel};
            end
            S_MOVE: begin
                m_a = {6'd0, r_step};
                m_b = ((r_op == OP_FWD) || (r_op == OP_BACK)) ? 32'(r_front[r_i])
                                                              : 32'(r_s[r_i]);
            end
            S_DOT: begin
                m_a   = r_pos[r_i];
                m_b   = (r_t == 2'd0) ? 32'(r_s[r_i]) :
                        (r_t == 2'd1) ? 32'(r_u[r_i]) : 32'(r_front[r_i]);
                m_clr = (r_i == 2'd0);
            end
            default: ;
        endcase
    end

    logic               w_mdone;
    logic signed [63:0] w_rnd14, w_msum, w_sqsum;
    logic               w_sub;
    logic [32:0]        w_dt;
    logic               w_dge;

    assign w_mdone = r_ph && (r_mcnt == 6'd0);
    assign w_rnd14 = (r_acc + 64'sd8192) >>> 14;
    assign w_sub   = (r_op == OP_BACK) || (r_op == OP_LEFT);
    assign w_msum  = 64'(r_pos[r_i]) + (w_sub ? -w_rnd14 : w_rnd14);
    assign w_sqsum = $signed(r_sr + r_bit);
    assign w_dt    = (r_dcnt == 4'd15) ? r_dr : {r_dr[31:0], 1'b0};
    assign w_dge   = (w_dt >= {1'b0, r_m});

    // Column being sent.
    logic [135:0] w_col;
    t_q16         w_r0, w_r1, w_r2, w_r3;

    always_comb begin
        if (r_i == 2'd3) begin
            w_r0 = r_col3[0];
            w_r1 = r_col3[1];
            w_r2 = r_col3[2];
            w_r3 = 32'sd65536;
        end else begin
            w_r0 = 32'(r_s[r_i]) <<< 2;
            w_r1 = 32'(r_u[r_i]) <<< 2;
            w_r2 = -(32'(r_front[r_i]) <<< 2);
            w_r3 = '0;
        end
        w_col = {6'd0, w_r3, w_r2, w_r1, w_r0, r_i};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_i      <= 2'd0;
            r_t      <= 2'd0;
            r_upass  <= 1'b0;
            r_op     <= OP_FWD;
            r_mcnt   <= 6'd0;
            r_ovalid <= 1'b0;
            r_up[0]  <= 16'sd0;
            r_up[1]  <= 16'sd16384;
            r_up[2]  <= 16'sd0;
            r_speed  <= 16'd328;
            r_accel  <= 10'd1;
            r_pos[0] <= 32'sd0;
            r_pos[1] <= 32'sd0;
            r_pos[2] <= 32'sd196608;
            r_front[0] <= 16'sd0;
            r_front[1] <= 16'sd0;
            r_front[2] <= -16'sd16384;
            r_pitch  <= 8'sd0;
            r_yaw    <= 9'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    CFG_UP_X:  r_up[0] <= i_cfg_data;
                    CFG_UP_Y:  r_up[1] <= i_cfg_data;
                    CFG_UP_Z:  r_up[2] <= i_cfg_data;
                    CFG_SPEED: r_speed <= i_cfg_data;
                    CFG_ACCEL: r_accel <= i_cfg_data[9:0];
                    default: ;
                endcase
            end

            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            // One multiplier bit per cycle; the top bit of the word carries negative weight.
            if (r_mcnt != 6'd0) begin
                if (r_mb[0]) begin
                    r_acc <= (r_mcnt == 6'd1) ? r_acc - r_ma : r_acc + r_ma;
                end
                r_ma   <= r_ma <<< 1;
                r_mb   <= r_mb >> 1;
                r_mcnt <= r_mcnt - 6'd1;
            end

            if ((r_state == S_FMUL || r_state == S_CROSS || r_state == S_SQ ||
                 r_state == S_STEP || r_state == S_MOVE || r_state == S_DOT) && !r_ph) begin
                r_ma   <= m_neg ? -64'(m_a) : 64'(m_a);
                r_mb   <= m_b;
                r_mcnt <= m_len;
                if (m_clr) begin
                    r_acc <= '0;
                end
                r_ph <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pitch <= n_pitch;
                        r_yaw   <= n_yaw;
                        r_op    <= w_op;
                        r_ph    <= 1'b0;
                        r_i     <= 2'd0;
                        r_t     <= 2'd0;
                        r_upass <= 1'b0;
                        case (w_op) inside
                            OP_FWD, OP_BACK:   r_state <= S_STEP;
                            OP_RIGHT, OP_LEFT: r_state <= S_CROSS;
                            OP_VIEW:           r_state <= S_TRIG;
                            OP_SET_POS: begin
                                r_pos[0] <= w_val[0];
                                r_pos[1] <= w_val[1];
                                r_pos[2] <= w_val[2];
                            end
                            OP_SET_FRONT: begin
                                r_front[0] <= n_front[0];
                                r_front[1] <= n_front[1];
                                r_front[2] <= n_front[2];
                            end
                            default: ;
                        endcase
                    end
                end

                S_TRIG: begin
                    if (!r_ph) begin
                        r_x    <= 34'(CORDIC_K);
                        r_y    <= '0;
                        r_z    <= w_zinit;
                        r_tneg <= w_dneg;
                        r_j    <= 5'd0;
                        r_ph   <= 1'b1;
                    end else if ((r_j != 5'(CORDIC_STEPS)) && (r_j != 5'd24)) begin
                        if (!r_z[33]) begin
                            r_x <= r_x - w_dx;
                            r_y <= r_y + w_dy;
                            r_z <= r_z - w_at;
                        end else begin
                            r_x <= r_x + w_dx;
                            r_y <= r_y - w_dy;
                            r_z <= r_z + w_at;
                        end
                        r_j <= r_j + 5'd1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_i == 2'd0) begin
                            r_sp <= w_cy;
                            r_cp <= w_cx;
                            r_i  <= 2'd1;
                        end else begin
                            r_sy    <= w_cy;
                            r_cy    <= w_cx;
                            r_i     <= 2'd0;
                            r_state <= S_FMUL;
                        end
                    end
                end

                // The new front is taken as a unit vector without renormalising.
                S_FMUL: begin
                    if (w_mdone) begin
                        r_ph <= 1'b0;
                        if (r_i == 2'd0) begin
                            r_front[0] <= w_rnd14[15:0];
                            r_i        <= 2'd1;
                        end else begin
                            r_front[2] <= w_rnd14[15:0];
                            r_front[1] <= r_sp;
                            r_i        <= 2'd0;
                            r_t        <= 2'd0;
                            r_upass    <= 1'b0;
                            r_state    <= S_CROSS;
                        end
                    end
                end

                // First pass: front x up, halved, for the side vector. Second pass: s x f.
                S_CROSS: begin
                    if (w_mdone) begin
                        r_ph <= 1'b0;
                        if (r_t == 2'd0) begin
                            r_t <= 2'd1;
                        end else begin
                            r_t <= 2'd0;
                            if (r_upass) begin
                                r_u[r_i] <= w_rnd14[17:0];
                            end else begin
                                r_c[r_i] <= r_acc[32:1];
                            end
                            if (r_i == 2'd2) begin
                                r_i     <= 2'd0;
                                r_state <= r_upass ? S_DOT : S_SQ;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end
                    end
                end

                S_SQ: begin
                    if (w_mdone) begin
                        r_ph <= 1'b0;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_state <= S_SQRT;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end

                // Integer square root, one result bit per cycle.
                S_SQRT: begin
                    if (!r_ph) begin
                        r_sv  <= r_acc;
                        r_sr  <= '0;
                        r_bit <= 64'd1 << 62;
                        r_ph  <= 1'b1;
                    end else if (r_bit != 64'd0) begin
                        if (r_sv >= 64'(w_sqsum)) begin
                            r_sv <= r_sv - 64'(w_sqsum);
                            r_sr <= (r_sr >> 1) + r_bit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_m     <= r_sr[31:0];
                        r_ph    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end

                // Restoring division of |c| * 2^14 by the norm, truncated toward zero. A zero
                // norm (front parallel to up) gives a zero side vector.
                S_DIV: begin
                    if (!r_ph && (r_m == 32'd0)) begin
                        r_s[r_i] <= '0;
                    end else if (!r_ph) begin
                        r_dr   <= r_c[r_i][31] ? 33'(-r_c[r_i]) : 33'(r_c[r_i]);
                        r_dneg <= r_c[r_i][31];
                        r_q    <= '0;
                        r_dcnt <= 4'd15;
                        r_ph   <= 1'b1;
                    end else if (r_dcnt != 4'd0) begin
                        r_dr   <= w_dge ? w_dt - {1'b0, r_m} : w_dt;
                        r_q    <= {r_q[13:0], w_dge};
                        r_dcnt <= r_dcnt - 4'd1;
                    end else begin
                        r_s[r_i] <= r_dneg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
                        r_ph     <= 1'b0;
                    end
                    if ((!r_ph && (r_m == 32'd0)) || (r_ph && (r_dcnt == 4'd0))) begin
                        if (r_i == 2'd2) begin
                            r_i <= 2'd0;
                            r_t <= 2'd0;
                            if (r_op == OP_VIEW) begin
                                r_upass <= 1'b1;
                                r_state <= S_CROSS;
                            end else begin
                                r_state <= S_STEP;
                            end
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end

                S_STEP: begin
                    if (w_mdone) begin
                        r_step  <= r_acc[25:0];
                        r_ph    <= 1'b0;
                        r_i     <= 2'd0;
                        r_state <= S_MOVE;
                    end
                end

                S_MOVE: begin
                    if (w_mdone) begin
                        r_pos[r_i] <= sat32(w_msum);
                        r_ph       <= 1'b0;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end

                // Translation column: -s.pos, -u.pos, f.pos.
                S_DOT: begin
                    if (w_mdone) begin
                        r_ph <= 1'b0;
                        if (r_i == 2'd2) begin
                            r_col3[r_t] <= sat32((r_t == 2'd2) ? w_rnd14 : -w_rnd14);
                            r_i         <= 2'd0;
                            if (r_t == 2'd2) begin
                                r_t     <= 2'd0;
                                r_state <= S_EMIT;
                            end else begin
                                r_t <= r_t + 2'd1;
                            end
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end

                S_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= w_col;
                        r_olast  <= (r_i == 2'd3);
                        r_ovalid <= 1'b1;
                        if (r_i == 2'd3) begin
                            r_i     <= 2'd0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
